[src/clp_pkg.sv]
// ----------------------------------------------------------------------------
// clp_pkg: shared types and constants for the longitudinal profile block
// Opcodes, sequencer states, memory control bundle and small helpers used by
// the profile datapath and its bin store.
// ----------------------------------------------------------------------------
package clp_pkg;

  localparam int LAYERS_DEF      = 100;
  localparam int ENERGY_BITS_DEF = 24;
  localparam int SUM_BITS_DEF    = 32;

  localparam int OPC_W   = 2;
  localparam int IDX_IN_W = 10;
  localparam int E_IN_W  = 24;
  localparam int LAY_W   = 7;
  localparam int OUT_W   = 32;
  localparam int FRAC_W  = 17;
  localparam int DIGIT_W = 4;

  localparam int FRAC_STEPS = 16;
  localparam int CNT_W      = $clog2(FRAC_STEPS);

  localparam logic [FRAC_W-1:0] Q_ONE = FRAC_W'(65536);

  typedef enum logic [OPC_W-1:0] {
    OP_DEPOSIT = 2'd0,
    OP_FINISH  = 2'd1,
    OP_READ    = 2'd2,
    OP_CLEAR   = 2'd3
  } clp_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DEP_RD,
    ST_DEP_WR,
    ST_FIN_RD,
    ST_FIN_ACC,
    ST_RD_MEM,
    ST_RD_CMP,
    ST_RD_DIV,
    ST_DONE
  } clp_state_t;

  typedef struct packed {
    logic lay_we;
    logic pre_we;
    logic clear;
  } clp_mem_ctl_t;

  // hundreds digit of a value below 1024, by reciprocal multiply
  function automatic logic [DIGIT_W-1:0] div100(input logic [IDX_IN_W-1:0] x);
    logic [23:0] p;
    p = 24'(x) * 24'd5243;
    return p[22:19];
  endfunction

  function automatic logic [LAY_W-1:0] layer_of(input logic [IDX_IN_W-1:0] cub,
                                                input logic [IDX_IN_W-1:0] cell_idx);
    logic [DIGIT_W-1:0] d1;
    logic [DIGIT_W-1:0] d2;
    d1 = div100(cub);
    d2 = div100(cell_idx);
    return LAY_W'({d1, 3'b000}) + LAY_W'({d1, 1'b0}) + LAY_W'(d2);
  endfunction

  // {flag, value}: value clamped to 32 bits, flag set when clamped
  function automatic logic [OUT_W:0] clamp32(input logic [63:0] v);
    if (|v[63:OUT_W]) begin
      return {1'b1, {OUT_W{1'b1}}};
    end
    return {1'b0, v[OUT_W-1:0]};
  endfunction

endpackage

[src/clp_alu.sv]
// ----------------------------------------------------------------------------
// clp_alu: shared adder and subtract-compare unit
// Adds, or subtracts with carry out as the greater-or-equal flag; used for bin
// updates, prefix accumulation and the fraction division steps.
// ----------------------------------------------------------------------------
module clp_alu #(
  parameter int W = 33
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic         sub,
  output logic [W:0]   res
);

  logic [W:0] b_ext;

  assign b_ext = sub ? {1'b0, ~b} : {1'b0, b};
  assign res   = {1'b0, a} + b_ext + (W+1)'(sub);

endmodule

[src/clp_bins.sv]
// ----------------------------------------------------------------------------
// clp_bins: layer bin and prefix sum store
// Two single-write memories with a shared read address and registered read
// data; layer bins carry valid bits so that reset and clear read back as zero.
// ----------------------------------------------------------------------------
module clp_bins #(
  parameter int LAYERS   = clp_pkg::LAYERS_DEF,
  parameter int SUM_BITS = clp_pkg::SUM_BITS_DEF,
  parameter int LIDX_W   = $clog2(clp_pkg::LAYERS_DEF)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  clp_pkg::clp_mem_ctl_t ctl,
  input  logic [LIDX_W-1:0]     rd_addr,
  input  logic [LIDX_W-1:0]     wr_addr,
  input  logic [SUM_BITS-1:0]   lay_wdata,
  input  logic [SUM_BITS-1:0]   pre_wdata,
  output logic [SUM_BITS-1:0]   lay_rdata,
  output logic [SUM_BITS-1:0]   pre_rdata
);
  import clp_pkg::*;

  logic [SUM_BITS-1:0] lay_mem [LAYERS];
  logic [SUM_BITS-1:0] pre_mem [LAYERS];
  logic [SUM_BITS-1:0] lay_rd_r;
  logic [SUM_BITS-1:0] pre_rd_r;
  logic [LAYERS-1:0]   vld_r;
  logic                rd_vld_r;

  always_ff @(posedge clk) begin
    if (ctl.lay_we) begin
      lay_mem[wr_addr] <= lay_wdata;
    end
    if (ctl.pre_we) begin
      pre_mem[wr_addr] <= pre_wdata;
    end
    lay_rd_r <= lay_mem[rd_addr];
    pre_rd_r <= pre_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (ctl.clear) begin
        vld_r <= '0;
      end else if (ctl.lay_we) begin
        vld_r[wr_addr] <= 1'b1;
      end
      rd_vld_r <= vld_r[rd_addr];
    end
  end

  assign lay_rdata = rd_vld_r ? lay_rd_r : '0;
  assign pre_rdata = pre_rd_r;

endmodule

[src/calorimeter_longitudinal_profile_top.sv]
// ----------------------------------------------------------------------------
// A deposit reads its bin, then writes it back (not past the end); a clear
//   acts on acceptance; a finish does a bin read and an adder step per layer;
//   a read does 16 division steps (none past the end, empty or full fraction).
// One item at a time: in_stall stays high until any result enters the output.
// Reset (synchronous, rst_n low): bins read as zero, total and overflow clear.
// ----------------------------------------------------------------------------
// calorimeter_longitudinal_profile_top: longitudinal energy profile
// Sums hit energies into depth bins, forms prefix sums and total on finish,
// and returns layer energy with its cumulative fraction of the total in Q1.16.
// ----------------------------------------------------------------------------
module calorimeter_longitudinal_profile_top #(
  parameter int LAYERS      = clp_pkg::LAYERS_DEF,
  parameter int ENERGY_BITS = clp_pkg::ENERGY_BITS_DEF,
  parameter int SUM_BITS    = clp_pkg::SUM_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [clp_pkg::OPC_W-1:0]    in_opcode,
  input  logic [clp_pkg::IDX_IN_W-1:0] in_cublet_index,
  input  logic [clp_pkg::IDX_IN_W-1:0] in_cell_index,
  input  logic [clp_pkg::E_IN_W-1:0]   in_energy,
  input  logic [clp_pkg::LAY_W-1:0]    in_layer_select,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [clp_pkg::OUT_W-1:0]    out_layer_energy,
  output logic [clp_pkg::FRAC_W-1:0]   out_cumulative_fraction,
  output logic [clp_pkg::OUT_W-1:0]    out_total_energy,
  output logic                        out_empty_event,
  output logic                        out_saturated
);
  import clp_pkg::*;

  localparam int LIDX_W = $clog2(LAYERS);
  localparam int ACC_W  = ((SUM_BITS > E_IN_W) ? SUM_BITS : E_IN_W) + 1;
  localparam int EB     = (ENERGY_BITS < E_IN_W) ? ENERGY_BITS : E_IN_W;
  localparam logic [E_IN_W-1:0]   E_MASK   = {E_IN_W{1'b1}} >> (E_IN_W - EB);
  localparam logic [LIDX_W-1:0]   LAST_IDX = LIDX_W'(LAYERS - 1);
  localparam logic [LAY_W-1:0]    LAYERS_L = LAY_W'(LAYERS);
  localparam logic [SUM_BITS-1:0] SUM_MAX  = {SUM_BITS{1'b1}};
  localparam logic [CNT_W-1:0]    CNT_LAST = CNT_W'(FRAC_STEPS - 1);

  clp_state_t state_r, state_nxt;

  logic [LIDX_W-1:0]   idx_r, idx_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [SUM_BITS-1:0] acc_r, acc_nxt;
  logic [FRAC_W-1:0]   quo_r, quo_nxt;
  logic [SUM_BITS-1:0] total_r, total_nxt;
  logic                ovf_r, ovf_nxt;
  logic [LAY_W-1:0]    lay_r, lay_nxt;
  logic [LAY_W-1:0]    sel_r, sel_nxt;
  logic [E_IN_W-1:0]   e_r, e_nxt;
  logic [OUT_W-1:0]    lay_out_r, lay_out_nxt;
  logic                lay_flag_r, lay_flag_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]    out_lay_r, out_lay_nxt;
  logic [FRAC_W-1:0]   out_frac_r, out_frac_nxt;
  logic [OUT_W-1:0]    out_tot_r, out_tot_nxt;
  logic                out_empty_r, out_empty_nxt;
  logic                out_sat_r, out_sat_nxt;

  logic                in_acc;
  logic                sel_ok;
  logic                lay_ok;
  logic                out_free;
  logic [OUT_W:0]      tot_clamp;
  logic [OUT_W:0]      lay_clamp;

  clp_mem_ctl_t        mem_ctl;
  logic [LIDX_W-1:0]   rd_addr;
  logic [LIDX_W-1:0]   wr_addr;
  logic [SUM_BITS-1:0] lay_wdata;
  logic [SUM_BITS-1:0] pre_wdata;
  logic [SUM_BITS-1:0] lay_rdata;
  logic [SUM_BITS-1:0] pre_rdata;

  logic [ACC_W-1:0]    alu_a;
  logic [ACC_W-1:0]    alu_b;
  logic                alu_sub;
  logic [ACC_W:0]      alu_res;
  logic                alu_sat;
  logic                alu_ge;
  logic [SUM_BITS-1:0] add_val;

  clp_alu #(.W(ACC_W)) u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .res (alu_res)
  );

  clp_bins #(
    .LAYERS   (LAYERS),
    .SUM_BITS (SUM_BITS),
    .LIDX_W   (LIDX_W)
  ) u_bins (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (mem_ctl),
    .rd_addr   (rd_addr),
    .wr_addr   (wr_addr),
    .lay_wdata (lay_wdata),
    .pre_wdata (pre_wdata),
    .lay_rdata (lay_rdata),
    .pre_rdata (pre_rdata)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign sel_ok    = (sel_r < LAYERS_L);
  assign lay_ok    = (lay_r < LAYERS_L);
  assign out_free  = !out_valid_r || !out_stall;
  assign alu_sat   = |alu_res[ACC_W:SUM_BITS];
  assign alu_ge    = alu_res[ACC_W];
  assign add_val   = alu_sat ? SUM_MAX : alu_res[SUM_BITS-1:0];
  assign tot_clamp = clamp32(64'(total_r));
  assign lay_clamp = clamp32(64'(lay_rdata));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (clp_op_t'(in_opcode))
            OP_DEPOSIT: state_nxt = ST_DEP_RD;
            OP_FINISH:  state_nxt = ST_FIN_RD;
            OP_READ:    state_nxt = ST_RD_MEM;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_DEP_RD:  state_nxt = lay_ok ? ST_DEP_WR : ST_IDLE;
      ST_DEP_WR:  state_nxt = ST_IDLE;
      ST_FIN_RD:  state_nxt = ST_FIN_ACC;
      ST_FIN_ACC: state_nxt = (idx_r == LAST_IDX) ? ST_DONE : ST_FIN_RD;
      ST_RD_MEM:  state_nxt = ST_RD_CMP;
      ST_RD_CMP: begin
        if (!sel_ok || (total_r == '0) || alu_ge) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_RD_DIV;
        end
      end
      ST_RD_DIV:  state_nxt = (cnt_r == CNT_LAST) ? ST_DONE : ST_RD_DIV;
      ST_DONE:    state_nxt = out_free ? ST_IDLE : ST_DONE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    acc_nxt       = acc_r;
    quo_nxt       = quo_r;
    total_nxt     = total_r;
    ovf_nxt       = ovf_r;
    lay_nxt       = lay_r;
    sel_nxt       = sel_r;
    e_nxt         = e_r;
    lay_out_nxt   = lay_out_r;
    lay_flag_nxt  = lay_flag_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_lay_nxt   = out_lay_r;
    out_frac_nxt  = out_frac_r;
    out_tot_nxt   = out_tot_r;
    out_empty_nxt = out_empty_r;
    out_sat_nxt   = out_sat_r;
    mem_ctl       = '0;
    rd_addr       = idx_r;
    wr_addr       = idx_r;
    lay_wdata     = add_val;
    pre_wdata     = add_val;
    alu_a         = ACC_W'(acc_r);
    alu_b         = ACC_W'(lay_rdata);
    alu_sub       = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          lay_nxt      = layer_of(in_cublet_index, in_cell_index);
          e_nxt        = in_energy & E_MASK;
          sel_nxt      = in_layer_select;
          idx_nxt      = '0;
          cnt_nxt      = '0;
          acc_nxt      = '0;
          quo_nxt      = '0;
          lay_out_nxt  = '0;
          lay_flag_nxt = 1'b0;
          if (clp_op_t'(in_opcode) == OP_CLEAR) begin
            mem_ctl.clear = 1'b1;
            total_nxt     = '0;
            ovf_nxt       = 1'b0;
          end
        end
      end
      ST_DEP_RD: begin
        if (lay_ok) begin
          rd_addr = lay_r[LIDX_W-1:0];
        end
      end
      ST_DEP_WR: begin
        alu_a          = ACC_W'(lay_rdata);
        alu_b          = ACC_W'(e_r);
        wr_addr        = lay_r[LIDX_W-1:0];
        mem_ctl.lay_we = 1'b1;
        if (alu_sat) begin
          ovf_nxt = 1'b1;
        end
      end
      ST_FIN_ACC: begin
        mem_ctl.pre_we = 1'b1;
        acc_nxt        = add_val;
        if (alu_sat) begin
          ovf_nxt = 1'b1;
        end
        if (idx_r == LAST_IDX) begin
          total_nxt = add_val;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_RD_MEM: begin
        if (sel_ok) begin
          rd_addr = sel_r[LIDX_W-1:0];
        end
      end
      ST_RD_CMP: begin
        alu_a   = ACC_W'(pre_rdata);
        alu_b   = ACC_W'(total_r);
        alu_sub = 1'b1;
        quo_nxt = '0;
        if (sel_ok) begin
          lay_flag_nxt = lay_clamp[OUT_W];
          lay_out_nxt  = lay_clamp[OUT_W-1:0];
          if (total_r != '0) begin
            if (alu_ge) begin
              quo_nxt = Q_ONE;
            end else begin
              acc_nxt = pre_rdata;
            end
          end
        end
      end
      ST_RD_DIV: begin
        alu_a   = ACC_W'({acc_r, 1'b0});
        alu_b   = ACC_W'(total_r);
        alu_sub = 1'b1;
        acc_nxt = alu_ge ? alu_res[SUM_BITS-1:0] : {acc_r[SUM_BITS-2:0], 1'b0};
        quo_nxt = {quo_r[FRAC_W-2:0], alu_ge};
        cnt_nxt = cnt_r + 1'b1;
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_lay_nxt   = lay_out_r;
          out_frac_nxt  = quo_r;
          out_tot_nxt   = tot_clamp[OUT_W-1:0];
          out_empty_nxt = (total_r == '0);
          out_sat_nxt   = ovf_r | lay_flag_r | tot_clamp[OUT_W];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      total_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    cnt_r       <= cnt_nxt;
    acc_r       <= acc_nxt;
    quo_r       <= quo_nxt;
    lay_r       <= lay_nxt;
    sel_r       <= sel_nxt;
    e_r         <= e_nxt;
    lay_out_r   <= lay_out_nxt;
    lay_flag_r  <= lay_flag_nxt;
    out_lay_r   <= out_lay_nxt;
    out_frac_r  <= out_frac_nxt;
    out_tot_r   <= out_tot_nxt;
    out_empty_r <= out_empty_nxt;
    out_sat_r   <= out_sat_nxt;
  end

  assign out_valid               = out_valid_r;
  assign out_layer_energy        = out_lay_r;
  assign out_cumulative_fraction = out_frac_r;
  assign out_total_energy        = out_tot_r;
  assign out_empty_event         = out_empty_r;
  assign out_saturated           = out_sat_r;

endmodule

[test/tb_calorimeter_longitudinal_profile_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_calorimeter_longitudinal_profile_top: self-checking bench for the profile
// Drives deposit, finish, read and clear items with random gaps and stalls
// on both sides. A behavioural profile predicts all but fixed rows' results.
// Directed rows cover the extremes, empty events, layers and selects past the
// end, and reads of stale prefix sums. Random events follow, and then one
// heavy event that drives the prefix sums and then one bin into saturation.
// ----------------------------------------------------------------------------
module tb_calorimeter_longitudinal_profile_top;
  import clp_pkg::*;

  localparam int NLAYERS      = LAYERS_DEF;
  localparam int EBITS        = ENERGY_BITS_DEF;
  localparam int SUM_W        = SUM_BITS_DEF;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int HOLD_CYCLES  = 600;
  localparam int DRAIN_CYCLES = 2 * NLAYERS + 50;
  localparam int REPORT_MAX   = 10;

  localparam logic [E_IN_W-1:0] E_FULL = {E_IN_W{1'b1}};

  typedef struct packed {
    logic [OUT_W-1:0]  layer_energy;
    logic [FRAC_W-1:0] fraction;
    logic [OUT_W-1:0]  total_energy;
    logic              empty_event;
    logic              saturated;
  } profile_t;

  typedef struct {
    clp_op_t            op;
    logic [IDX_IN_W-1:0] cub;
    logic [IDX_IN_W-1:0] cell_idx;
    logic [E_IN_W-1:0]   energy;
    logic [LAY_W-1:0]    sel;
    logic               fixed;
    profile_t           want;
  } profile_cmd_t;

  localparam profile_t NO_RESULT    = '0;
  localparam profile_t EMPTY_RESULT = '{layer_energy: '0, fraction: '0, total_energy: '0,
                                        empty_event: 1'b1, saturated: 1'b0};
  localparam profile_t STALE_READ   = '{layer_energy: 32'h00FF_FFFF, fraction: '0,
                                        total_energy: '0, empty_event: 1'b1,
                                        saturated: 1'b0};

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [OPC_W-1:0]    in_opcode = '0;
  logic [IDX_IN_W-1:0] in_cublet_index = '0;
  logic [IDX_IN_W-1:0] in_cell_index = '0;
  logic [E_IN_W-1:0]   in_energy = '0;
  logic [LAY_W-1:0]    in_layer_select = '0;
  logic                out_valid;
  logic                out_stall;
  logic [OUT_W-1:0]    out_layer_energy;
  logic [FRAC_W-1:0]   out_cumulative_fraction;
  logic [OUT_W-1:0]    out_total_energy;
  logic                out_empty_event;
  logic                out_saturated;

  logic rx_stall = 1'b0;
  logic hold_stall = 1'b0;
  assign out_stall = rx_stall | hold_stall;

  calorimeter_longitudinal_profile_top DUT (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_stall                (in_stall),
    .in_opcode               (in_opcode),
    .in_cublet_index         (in_cublet_index),
    .in_cell_index           (in_cell_index),
    .in_energy               (in_energy),
    .in_layer_select         (in_layer_select),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_layer_energy        (out_layer_energy),
    .out_cumulative_fraction (out_cumulative_fraction),
    .out_total_energy        (out_total_energy),
    .out_empty_event         (out_empty_event),
    .out_saturated           (out_saturated)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  profile_cmd_t directed_rows [21] = '{
    '{OP_FINISH,  10'd0,    10'd0,    24'd0,      7'd0,   1'b1, EMPTY_RESULT},
    '{OP_READ,    10'd0,    10'd0,    24'd0,      7'd0,   1'b1, EMPTY_RESULT},
    '{OP_READ,    10'd1023, 10'd1023, E_FULL,     7'd127, 1'b1, EMPTY_RESULT},
    '{OP_DEPOSIT, 10'd0,    10'd0,    E_FULL,     7'd0,   1'b0, NO_RESULT},
    '{OP_DEPOSIT, 10'd999,  10'd999,  24'd1,      7'd127, 1'b0, NO_RESULT},
    '{OP_DEPOSIT, 10'd1023, 10'd0,    E_FULL,     7'd0,   1'b0, NO_RESULT},
    '{OP_DEPOSIT, 10'd999,  10'd1000, 24'd5,      7'd0,   1'b0, NO_RESULT},
    '{OP_DEPOSIT, 10'd500,  10'd1023, 24'h800000, 7'd0,   1'b0, NO_RESULT},
    '{OP_DEPOSIT, 10'd0,    10'd1023, 24'h123456, 7'd0,   1'b0, NO_RESULT},
    '{OP_READ,    10'd0,    10'd0,    24'd0,      7'd0,   1'b1, STALE_READ},
    '{OP_FINISH,  10'd0,    10'd0,    24'd0,      7'd0,   1'b0, NO_RESULT},
    '{OP_READ,    10'd0,    10'd0,    24'd0,      7'd0,   1'b0, NO_RESULT},
    '{OP_READ,    10'd0,    10'd0,    24'd0,      7'd10,  1'b0, NO_RESULT},
    '{OP_READ,    10'd0,    10'd0,    24'd0,      7'd50,  1'b0, NO_RESULT},
    '{OP_READ,    10'd0,    10'd0,    24'd0,      7'd60,  1'b0, NO_RESULT},
    '{OP_READ,    10'd0,    10'd0,    24'd0,      7'd99,  1'b0, NO_RESULT},
    '{OP_READ,    10'd0,    10'd0,    24'd0,      7'd100, 1'b0, NO_RESULT},
    '{OP_DEPOSIT, 10'd0,    10'd0,    24'd0,      7'd0,   1'b0, NO_RESULT},
    '{OP_CLEAR,   10'd0,    10'd0,    24'd0,      7'd0,   1'b0, NO_RESULT},
    '{OP_READ,    10'd0,    10'd0,    24'd0,      7'd99,  1'b1, EMPTY_RESULT},
    '{OP_FINISH,  10'd0,    10'd0,    24'd0,      7'd0,   1'b1, EMPTY_RESULT}
  };

  logic [SUM_W-1:0] bin_sum [NLAYERS];
  logic [SUM_W-1:0] prefix_sum [NLAYERS];
  logic [SUM_W-1:0] event_sum;
  logic             overflow_flag;

  profile_cmd_t plan [$];
  profile_cmd_t offer_cmd;
  profile_t     pending_results [$];
  int unsigned  fault_count = 0;
  int unsigned  items_sent = 0;
  int unsigned  cycle_count = 0;

  function automatic void clear_profile();
    foreach (bin_sum[i]) begin
      bin_sum[i] = '0;
      prefix_sum[i] = '0;
    end
    event_sum = '0;
    overflow_flag = 1'b0;
  endfunction

  function automatic logic [SUM_W-1:0] add_saturating(input logic [SUM_W-1:0] a,
                                                     input logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s[SUM_W]) begin
      overflow_flag = 1'b1;
      return '1;
    end
    return s[SUM_W-1:0];
  endfunction

  function automatic logic [OUT_W-1:0] clamp_out(input logic [SUM_W-1:0] v,
                                                inout logic sat);
    if (64'(v) > 64'hFFFF_FFFF) begin
      sat = 1'b1;
      return '1;
    end
    return OUT_W'(v);
  endfunction

  function automatic logic [FRAC_W-1:0] q16_share(input logic [SUM_W-1:0] num,
                                                 input logic [SUM_W-1:0] den);
    logic [SUM_W:0]    r;
    logic [FRAC_W-1:0] q;
    if (num >= den) return Q_ONE;
    r = {1'b0, num};
    q = '0;
    for (int i = 0; i < 16; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= {1'b0, den}) begin
        r = r - {1'b0, den};
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  // advance the profile by one item; return 1 when the item yields a result
  function automatic bit advance_profile(input profile_cmd_t c, output profile_t r);
    int unsigned      depth;
    logic [SUM_W-1:0] acc;
    logic             sat;
    r = '0;
    case (c.op)
      OP_DEPOSIT: begin
        depth = (int'(c.cub) / 100) * 10 + int'(c.cell_idx) / 100;
        if (depth < NLAYERS) begin
          bin_sum[depth] = add_saturating(bin_sum[depth], SUM_W'(c.energy[EBITS-1:0]));
        end
        return 1'b0;
      end
      OP_CLEAR: begin
        clear_profile();
        return 1'b0;
      end
      OP_FINISH: begin
        acc = '0;
        for (int i = 0; i < NLAYERS; i++) begin
          acc = add_saturating(acc, bin_sum[i]);
          prefix_sum[i] = acc;
        end
        event_sum = acc;
      end
      default: ;
    endcase
    sat = overflow_flag;
    if (c.op == OP_READ && c.sel < NLAYERS) begin
      r.layer_energy = clamp_out(bin_sum[c.sel], sat);
      r.fraction = (event_sum == '0) ? '0 : q16_share(prefix_sum[c.sel], event_sum);
    end
    r.total_energy = clamp_out(event_sum, sat);
    r.empty_event = (event_sum == '0);
    r.saturated = sat;
    return 1'b1;
  endfunction

  function automatic profile_cmd_t random_cmd(input clp_op_t op);
    profile_cmd_t c;
    c.op = op;
    c.cub = ($urandom_range(0, 15) == 0) ? IDX_IN_W'($urandom_range(1000, 1023))
                                         : IDX_IN_W'($urandom_range(0, 999));
    c.cell_idx = ($urandom_range(0, 15) == 0) ? IDX_IN_W'($urandom_range(1000, 1023))
                                              : IDX_IN_W'($urandom_range(0, 999));
    case ($urandom_range(0, 3))
      0: c.energy = E_IN_W'($urandom_range(0, 255));
      1: c.energy = E_FULL - E_IN_W'($urandom_range(0, 255));
      default: c.energy = E_IN_W'($urandom);
    endcase
    c.sel = ($urandom_range(0, 7) == 0) ? LAY_W'($urandom_range(100, 127))
                                        : LAY_W'($urandom_range(0, 99));
    c.fixed = 1'b0;
    c.want = NO_RESULT;
    return c;
  endfunction

  function automatic profile_cmd_t aimed_hit(input int unsigned layer);
    profile_cmd_t c;
    c = random_cmd(OP_DEPOSIT);
    c.cub = IDX_IN_W'((layer / 10) * 100 + $urandom_range(0, 99));
    c.cell_idx = IDX_IN_W'((layer % 10) * 100 + $urandom_range(0, 99));
    c.energy = E_FULL;
    return c;
  endfunction

  function automatic profile_cmd_t read_of(input int unsigned layer);
    profile_cmd_t c;
    c = random_cmd(OP_READ);
    c.sel = LAY_W'(layer);
    return c;
  endfunction

  function automatic void add_step(input profile_cmd_t c);
    plan.insert(plan.size(), c);
  endfunction

  function automatic void build_plan();
    int unsigned deep_a;
    int unsigned deep_b;
    foreach (directed_rows[i]) add_step(directed_rows[i]);
    repeat (16) begin
      if ($urandom_range(0, 2) == 0) add_step(random_cmd(OP_CLEAR));
      repeat ($urandom_range(1, 12)) begin
        if ($urandom_range(0, 7) == 0) begin
          add_step(random_cmd(clp_op_t'($urandom_range(0, 3))));
        end
        add_step(random_cmd(OP_DEPOSIT));
      end
      add_step(random_cmd(OP_FINISH));
      repeat ($urandom_range(1, 4)) add_step(random_cmd(OP_READ));
    end
    // fill one bin to just below the top, tip the prefix over, then the bin itself
    deep_a = $urandom_range(0, NLAYERS - 1);
    do deep_b = $urandom_range(0, NLAYERS - 1); while (deep_b == deep_a);
    add_step(random_cmd(OP_CLEAR));
    repeat (256) add_step(aimed_hit(deep_a));
    add_step(aimed_hit(deep_b));
    add_step(random_cmd(OP_FINISH));
    add_step(read_of(deep_a));
    add_step(read_of(deep_b));
    add_step(random_cmd(OP_READ));
    add_step(aimed_hit(deep_a));
    add_step(random_cmd(OP_FINISH));
    add_step(read_of(deep_a));
    add_step(read_of(deep_b));
    add_step(random_cmd(OP_READ));
    add_step(random_cmd(OP_CLEAR));
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin : score_results
    profile_t calc;
    profile_t want;
    profile_t got;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        if (advance_profile(offer_cmd, calc)) begin
          pending_results.insert(pending_results.size(),
                                 offer_cmd.fixed ? offer_cmd.want : calc);
        end
      end
      if (out_valid && !out_stall) begin
        got = '{out_layer_energy, out_cumulative_fraction, out_total_energy,
                out_empty_event, out_saturated};
        if (pending_results.size() == 0) begin
          fault_count++;
          if (fault_count <= REPORT_MAX) begin
            $display("unexpected result: layer=%0d frac=%0d total=%0d empty=%0b sat=%0b",
                     got.layer_energy, got.fraction, got.total_energy,
                     got.empty_event, got.saturated);
          end
        end else begin
          want = pending_results.pop_front();
          if (got.layer_energy !== want.layer_energy || got.fraction !== want.fraction ||
              got.total_energy !== want.total_energy ||
              got.empty_event !== want.empty_event || got.saturated !== want.saturated) begin
            fault_count++;
            if (fault_count <= REPORT_MAX) begin
              $display("mismatch: expected layer=%0d frac=%0d total=%0d empty=%0b sat=%0b",
                       want.layer_energy, want.fraction, want.total_energy,
                       want.empty_event, want.saturated);
              $display("          actual   layer=%0d frac=%0d total=%0d empty=%0b sat=%0b",
                       got.layer_energy, got.fraction, got.total_energy,
                       got.empty_event, got.saturated);
            end
          end
        end
      end
    end
  end

  initial begin : result_sink
    int unsigned pause;
    int unsigned calm_left;
    calm_left = 0;
    forever begin
      if (calm_left > 0) begin
        pause = 0;
        calm_left--;
      end else begin
        pause = $urandom_range(0, 18);
        if ($urandom_range(0, 24) == 0) calm_left = $urandom_range(8, 40);
      end
      if (pause > 0) begin
        rx_stall <= 1'b1;
        repeat (pause) @(posedge clk);
        rx_stall <= 1'b0;
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  initial begin : long_hold
    wait (items_sent >= 40);
    repeat ($urandom_range(1, 30)) @(posedge clk);
    hold_stall <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_stall <= 1'b0;
  end

  initial begin : item_source
    int unsigned gap;
    int unsigned calm_left;
    calm_left = 0;
    clear_profile();
    build_plan();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    foreach (plan[k]) begin
      if (calm_left > 0) begin
        gap = 0;
        calm_left--;
      end else begin
        gap = $urandom_range(0, 18);
        if ($urandom_range(0, 24) == 0) calm_left = $urandom_range(8, 40);
      end
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid        <= 1'b1;
      in_opcode       <= plan[k].op;
      in_cublet_index <= plan[k].cub;
      in_cell_index   <= plan[k].cell_idx;
      in_energy       <= plan[k].energy;
      in_layer_select <= plan[k].sel;
      offer_cmd       <= plan[k];
      do @(posedge clk); while (in_stall);
      items_sent++;
    end
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    fault_count += pending_results.size();
    if (fault_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
